FILE: hdl/sps_pkg.sv
// Shared types, codes and constants of the SPS header parser.
// No dependencies; sps_front, sps_back and the top level import this package.
package sps_pkg;

   localparam int AccWidth = 33;

   // Parse positions that are not emitted as elements.
   localparam logic [5:0] POS_RESERVED = 6'd38;
   localparam logic [5:0] POS_SKIP     = 6'd39;

   localparam logic [5:0] CODE_PROFILE   = 6'd0;
   localparam logic [5:0] CODE_FLAG0     = 6'd1;
   localparam logic [5:0] CODE_LEVEL     = 6'd7;
   localparam logic [5:0] CODE_FLAG5     = 6'd6;
   localparam logic [5:0] CODE_SPS_ID    = 6'd8;
   localparam logic [5:0] CODE_CHROMA    = 6'd9;
   localparam logic [5:0] CODE_SEP_PLANE = 6'd10;
   localparam logic [5:0] CODE_DEPTH_L   = 6'd11;
   localparam logic [5:0] CODE_DEPTH_C   = 6'd12;
   localparam logic [5:0] CODE_SCALING   = 6'd14;
   localparam logic [5:0] CODE_FRAME_NUM = 6'd15;
   localparam logic [5:0] CODE_POC_TYPE  = 6'd16;
   localparam logic [5:0] CODE_POC_LSB   = 6'd17;
   localparam logic [5:0] CODE_DELTA_Z   = 6'd18;
   localparam logic [5:0] CODE_OFS_NREF  = 6'd19;
   localparam logic [5:0] CODE_OFS_TB    = 6'd20;
   localparam logic [5:0] CODE_CYCLE_N   = 6'd21;
   localparam logic [5:0] CODE_REF_FR    = 6'd22;
   localparam logic [5:0] CODE_MB_W      = 6'd24;
   localparam logic [5:0] CODE_MB_H      = 6'd25;
   localparam logic [5:0] CODE_FRM_ONLY  = 6'd26;
   localparam logic [5:0] CODE_MBAFF     = 6'd27;
   localparam logic [5:0] CODE_DIRECT8   = 6'd28;
   localparam logic [5:0] CODE_CROP_FLAG = 6'd29;
   localparam logic [5:0] CODE_CROP_L    = 6'd30;
   localparam logic [5:0] CODE_CROP_R    = 6'd31;
   localparam logic [5:0] CODE_CROP_T    = 6'd32;
   localparam logic [5:0] CODE_CROP_B    = 6'd33;
   localparam logic [5:0] CODE_VUI       = 6'd34;
   localparam logic [5:0] CODE_WIDTH     = 6'd35;
   localparam logic [5:0] CODE_HEIGHT    = 6'd36;
   localparam logic [5:0] CODE_ERROR     = 6'd37;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_RES_POC   = 3'd2,
      ST_SCALING   = 3'd3,
      ST_TRUNCATED = 3'd4,
      ST_UE_OVF    = 3'd5,
      ST_CHROMA    = 3'd6,
      ST_CROP      = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      B_IDLE, B_BIT, B_FAIL, B_FIN_CALC, B_FIN_W, B_FIN_H, B_END
   } back_state_type;

   // One queued byte between the front and the back.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_set;
   } byte_entry_type;

   function automatic logic high_ext(input logic [7:0] p);
      return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
             p == 8'd44  || p == 8'd83  || p == 8'd86  || p == 8'd118 ||
             p == 8'd128 || p == 8'd138 || p == 8'd139 || p == 8'd134 ||
             p == 8'd135;
   endfunction

   function automatic logic is_se_pos(input logic [5:0] p);
      return p == CODE_OFS_NREF || p == CODE_OFS_TB || p == POS_SKIP;
   endfunction

   function automatic logic is_ue_pos(input logic [5:0] p);
      return p == CODE_SPS_ID || p == CODE_CHROMA || p == CODE_DEPTH_L ||
             p == CODE_DEPTH_C || p == CODE_FRAME_NUM || p == CODE_POC_TYPE ||
             p == CODE_POC_LSB || p == CODE_CYCLE_N || p == CODE_REF_FR ||
             p == CODE_MB_W || p == CODE_MB_H ||
             (p >= CODE_CROP_L && p <= CODE_CROP_B);
   endfunction

   function automatic logic is_fixed_pos(input logic [5:0] p);
      return p == CODE_PROFILE || p == CODE_LEVEL || p == POS_RESERVED;
   endfunction

endpackage

FILE: hdl/sps_if.sv
// Valid/ready channel interfaces for the SPS parser's byte input and result output.
// Depends on nothing but the standard types.
interface sps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_set;
   modport source (output valid, output data_byte, output end_of_set, input ready);
   modport sink   (input valid, input data_byte, input end_of_set, output ready);
endinterface

interface sps_rsp_if;
   logic              valid;
   logic              ready;
   logic [5:0]        element_code;
   logic signed [32:0] element_value;
   logic [2:0]        status;
   logic              final_result;
   modport source (output valid, output element_code, output element_value,
                   output status, output final_result, input ready);
   modport sink   (input valid, input element_code, input element_value,
                   input status, input final_result, output ready);
endinterface

FILE: hdl/sps_front.sv
// Front of the SPS parser: accepts bytes and holds them in a two-entry queue.
// Depends on sps_pkg and sps_req_if.
module sps_front (
   input  logic                    clock,
   input  logic                    reset,
   sps_req_if.sink                 req_chan,
   output logic                    q_valid,
   output sps_pkg::byte_entry_type q_entry,
   input  logic                    q_pop
);
   import sps_pkg::*;

   byte_entry_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req_chan.ready = (count_ff != 2'd2);
   assign push    = req_chan.valid && req_chan.ready;
   assign q_valid = (count_ff != 2'd0);
   assign pop     = q_pop && q_valid;
   assign q_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{data_byte: req_chan.data_byte,
                                end_of_set: req_chan.end_of_set};
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push) else $error("push into full queue");

endmodule

FILE: hdl/sps_back.sv
// Back of the SPS parser: bit-serial Exp-Golomb decoder, syntax sequencer and
// picture size computation, with the result output register. Depends on sps_pkg and sps_rsp_if.
module sps_back #(
   parameter int MAX_CODE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  sps_pkg::byte_entry_type q_entry,
   output logic                    q_pop,
   sps_rsp_if.source               rsp_chan
);
   import sps_pkg::*;

   localparam int LzW = $clog2(MAX_CODE_BITS);
   localparam logic [LzW:0] MaxBits = (LzW + 1)'(MAX_CODE_BITS);

   back_state_type state_ff, state_in;

   logic [7:0]          sh_ff, sh_in;
   logic [2:0]          bitidx_ff, bitidx_in;
   logic                last_ff, last_in;
   logic [1:0]          bytes_ff, bytes_in;
   logic [5:0]          pos_ff, pos_in;
   logic [LzW-1:0]      bc_ff, bc_in;
   logic [LzW-1:0]      lz_ff, lz_in;
   logic [AccWidth-1:0] acc_ff, acc_in;
   logic [31:0]         skip_ff, skip_in;
   logic [7:0]          prof_ff, prof_in;
   logic [31:0]         chroma_ff, chroma_in;
   logic [2:0]          flags_ff, flags_in;
   logic [31:0]         sizes_ff [6];
   logic [31:0]         sizes_in [6];
   logic                done_ff, done_in;
   status_type          pend_ff, pend_in;
   logic [36:0]         w_ff, w_in;
   logic [37:0]         h_ff, h_in;
   logic [33:0]         cw_ff, cw_in;
   logic [34:0]         ch_ff, ch_in;
   logic [31:0]         hres_ff, hres_in;

   logic                 ov_ff, ov_in;
   logic [5:0]           ocode_ff, ocode_in;
   logic [AccWidth-1:0]  oval_ff, oval_in;
   status_type           ostat_ff, ostat_in;
   logic                 ofin_ff, ofin_in;

   logic out_free;
   logic bit_fail_pend, bit_finish, fin_err;
   logic b;

   assign out_free = !ov_ff || rsp_chan.ready;
   assign b        = sh_ff[7];
   assign q_pop    = (state_ff == B_IDLE) && q_valid;

   assign rsp_chan.valid         = ov_ff;
   assign rsp_chan.element_code  = ocode_ff;
   assign rsp_chan.element_value = oval_ff;
   assign rsp_chan.status        = ostat_ff;
   assign rsp_chan.final_result  = ofin_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:     if (q_valid) state_in = B_BIT;
         B_BIT: begin
            if (out_free) begin
               priority if (done_ff)    state_in = B_END;
               else if (bit_fail_pend)  state_in = B_FAIL;
               else if (bit_finish)     state_in = B_FIN_CALC;
               else if (bitidx_ff == 3'd7) state_in = B_END;
               else                     state_in = B_BIT;
            end
         end
         B_FAIL:     if (out_free) state_in = B_END;
         B_FIN_CALC: state_in = B_FIN_W;
         B_FIN_W:    if (out_free) state_in = fin_err ? B_END : B_FIN_H;
         B_FIN_H:    if (out_free) state_in = B_END;
         B_END:      if (out_free) state_in = B_IDLE;
         default:    state_in = B_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      logic                emit, cpl, cpl_se;
      logic [AccWidth-1:0] k, val, acc_sh;
      logic [AccWidth:0]   kp1;
      logic [31:0]         v;
      logic [3:0]          len;
      logic [LzW-1:0]      bc_dec;
      logic [36:0]         wr;
      logic [37:0]         hr;
      logic                mul1, cx2;
      logic [1:0]          cys;
      logic [32:0]         sx, sy;

      sh_in = sh_ff; bitidx_in = bitidx_ff; last_in = last_ff; bytes_in = bytes_ff;
      pos_in = pos_ff; bc_in = bc_ff; lz_in = lz_ff; acc_in = acc_ff;
      skip_in = skip_ff; prof_in = prof_ff; chroma_in = chroma_ff;
      flags_in = flags_ff; sizes_in = sizes_ff; done_in = done_ff; pend_in = pend_ff;
      w_in = w_ff; h_in = h_ff; cw_in = cw_ff; ch_in = ch_ff; hres_in = hres_ff;
      ocode_in = ocode_ff; oval_in = oval_ff; ostat_in = ostat_ff; ofin_in = ofin_ff;
      ov_in = ov_ff && !rsp_chan.ready;
      bit_fail_pend = 1'b0; bit_finish = 1'b0; fin_err = 1'b0;
      emit = 1'b0; cpl = 1'b0; cpl_se = 1'b0; k = '0; val = '0; v = '0;
      kp1 = '0; acc_sh = '0; bc_dec = '0; wr = '0; hr = '0;
      mul1 = 1'b0; cx2 = 1'b0; cys = 2'd0; sx = '0; sy = '0;
      len = (pos_ff == POS_RESERVED) ? 4'd2 : 4'd8;

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               sh_in     = q_entry.data_byte;
               last_in   = q_entry.end_of_set;
               bitidx_in = 3'd0;
               if (bytes_ff != 2'd3) bytes_in = bytes_ff + 2'd1;
            end
         end
         B_BIT: begin
            if (out_free && !done_ff) begin
               sh_in     = {sh_ff[6:0], 1'b0};
               bitidx_in = bitidx_ff + 3'd1;
               acc_sh    = {acc_ff[AccWidth-2:0], b};
               if (is_fixed_pos(pos_ff)) begin
                  acc_in = {{(AccWidth-8){1'b0}}, acc_sh[7:0]};
                  bc_in  = bc_ff + 1'b1;
                  if (bc_in >= LzW'(len)) begin
                     cpl = 1'b1;
                     k   = acc_in;
                  end
               end else if (is_se_pos(pos_ff) || is_ue_pos(pos_ff)) begin
                  cpl_se = is_se_pos(pos_ff);
                  if (bc_ff == '0) begin
                     if (!b) begin
                        if ({1'b0, lz_ff} + 1'b1 >= MaxBits) begin
                           emit     = 1'b1;
                           ocode_in = CODE_ERROR;
                           oval_in  = '0;
                           ostat_in = ST_UE_OVF;
                           ofin_in  = 1'b1;
                           done_in  = 1'b1;
                        end else begin
                           lz_in = lz_ff + 1'b1;
                        end
                     end else if (lz_ff == '0) begin
                        cpl = 1'b1;
                        k   = '0;
                     end else begin
                        bc_in  = lz_ff;
                        acc_in = AccWidth'(1);
                     end
                  end else begin
                     acc_in = acc_sh;
                     bc_dec = bc_ff - 1'b1;
                     bc_in  = bc_dec;
                     if (bc_dec == '0) begin
                        cpl = 1'b1;
                        k   = acc_sh - AccWidth'(1);
                     end
                  end
               end else begin
                  cpl = 1'b1;
                  k   = AccWidth'(b);
               end

               if (cpl) begin
                  v      = k[31:0];
                  kp1    = {1'b0, k} + 1'b1;
                  val    = cpl_se ? (k[0] ? kp1[AccWidth:1] : (AccWidth'(0) - (k >> 1))) : k;
                  bc_in  = '0;
                  lz_in  = '0;
                  acc_in = '0;
                  if (pos_ff != POS_RESERVED && pos_ff != POS_SKIP) begin
                     emit     = 1'b1;
                     ocode_in = pos_ff;
                     oval_in  = val;
                     ostat_in = ST_OK;
                     ofin_in  = 1'b0;
                  end
                  pos_in = pos_ff + 6'd1;
                  priority case (pos_ff)
                     CODE_PROFILE: prof_in = v[7:0];
                     CODE_FLAG5:   pos_in = POS_RESERVED;
                     POS_RESERVED: pos_in = CODE_LEVEL;
                     CODE_SPS_ID:  pos_in = high_ext(prof_ff) ? CODE_CHROMA : CODE_FRAME_NUM;
                     CODE_CHROMA: begin
                        chroma_in = v;
                        pos_in    = (v == 32'd3) ? CODE_SEP_PLANE : CODE_DEPTH_L;
                     end
                     CODE_SEP_PLANE: flags_in[0] = v[0];
                     CODE_SCALING: begin
                        if (v != '0) begin
                           bit_fail_pend = 1'b1;
                           pend_in       = ST_SCALING;
                        end
                     end
                     CODE_POC_TYPE: begin
                        if (v == 32'd0)      pos_in = CODE_POC_LSB;
                        else if (v == 32'd1) pos_in = CODE_DELTA_Z;
                        else if (v == 32'd2) pos_in = CODE_REF_FR;
                        else begin
                           bit_fail_pend = 1'b1;
                           pend_in       = ST_RES_POC;
                        end
                     end
                     CODE_POC_LSB: pos_in = CODE_REF_FR;
                     CODE_CYCLE_N: begin
                        skip_in = v;
                        pos_in  = (v != '0) ? POS_SKIP : CODE_REF_FR;
                     end
                     POS_SKIP: begin
                        skip_in = skip_ff - 32'd1;
                        pos_in  = (skip_in == '0) ? CODE_REF_FR : POS_SKIP;
                     end
                     CODE_MB_W: sizes_in[0] = v;
                     CODE_MB_H: sizes_in[1] = v;
                     CODE_FRM_ONLY: begin
                        flags_in[1] = v[0];
                        pos_in      = (v != '0) ? CODE_DIRECT8 : CODE_MBAFF;
                     end
                     CODE_CROP_FLAG: begin
                        flags_in[2] = v[0];
                        pos_in      = (v != '0) ? CODE_CROP_L : CODE_VUI;
                     end
                     CODE_CROP_L: sizes_in[2] = v;
                     CODE_CROP_R: sizes_in[3] = v;
                     CODE_CROP_T: sizes_in[4] = v;
                     CODE_CROP_B: sizes_in[5] = v;
                     CODE_VUI: begin
                        pos_in     = pos_ff;
                        bit_finish = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
         end
         B_FAIL: begin
            if (out_free) begin
               emit = 1'b1; ocode_in = CODE_ERROR; oval_in = '0;
               ostat_in = pend_ff; ofin_in = 1'b1; done_in = 1'b1;
            end
         end
         B_FIN_CALC: begin
            mul1 = flags_ff[1];
            if (chroma_ff == 32'd1)      begin cx2 = 1'b1; cys = mul1 ? 2'd1 : 2'd2; end
            else if (chroma_ff == 32'd2) begin cx2 = 1'b1; cys = mul1 ? 2'd0 : 2'd1; end
            else                         begin cx2 = 1'b0; cys = mul1 ? 2'd0 : 2'd1; end
            sx    = {1'b0, sizes_ff[2]} + {1'b0, sizes_ff[3]};
            sy    = {1'b0, sizes_ff[4]} + {1'b0, sizes_ff[5]};
            w_in  = {({1'b0, sizes_ff[0]} + 33'd1), 4'd0};
            h_in  = {1'b0, ({1'b0, sizes_ff[1]} + 33'd1), 4'd0} << (mul1 ? 0 : 1);
            cw_in = {1'b0, sx} << cx2;
            ch_in = {2'b0, sy} << cys;
         end
         B_FIN_W: begin
            if (out_free) begin
               emit = 1'b1;
               wr   = w_ff;
               hr   = h_ff;
               if (flags_ff[2]) begin
                  wr = w_ff - {3'b0, cw_ff};
                  hr = h_ff - {3'b0, ch_ff};
               end
               if (chroma_ff > 32'd3) begin
                  fin_err = 1'b1; ostat_in = ST_CHROMA;
               end else if (flags_ff[2] &&
                            ({3'b0, cw_ff} >= w_ff || {3'b0, ch_ff} >= h_ff)) begin
                  fin_err = 1'b1; ostat_in = ST_CROP;
               end else begin
                  ostat_in = ST_OK;
               end
               if (fin_err) begin
                  ocode_in = CODE_ERROR; oval_in = '0; ofin_in = 1'b1; done_in = 1'b1;
               end else begin
                  ocode_in = CODE_WIDTH; ofin_in = 1'b0;
                  oval_in  = {1'b0, (wr[36:32] != '0) ? 32'hFFFF_FFFF : wr[31:0]};
                  hres_in  = (hr[37:32] != '0) ? 32'hFFFF_FFFF : hr[31:0];
               end
            end
         end
         B_FIN_H: begin
            if (out_free) begin
               emit = 1'b1; ocode_in = CODE_HEIGHT; oval_in = {1'b0, hres_ff};
               ostat_in = ST_OK; ofin_in = 1'b1; done_in = 1'b1;
            end
         end
         B_END: begin
            if (out_free && last_ff) begin
               if (!done_ff) begin
                  emit = 1'b1; ocode_in = CODE_ERROR; oval_in = '0; ofin_in = 1'b1;
                  ostat_in = (bytes_ff != 2'd3) ? ST_SHORT : ST_TRUNCATED;
               end
               pos_in = CODE_PROFILE; bc_in = '0; lz_in = '0; acc_in = '0;
               skip_in = '0; prof_in = '0; chroma_in = 32'd1; flags_in = '0;
               for (int i = 0; i < 6; i++) sizes_in[i] = '0;
               bytes_in = 2'd0; done_in = 1'b0;
            end
         end
         default: ;
      endcase
      if (emit) ov_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         ov_ff     <= 1'b0;
         bytes_ff  <= 2'd0;
         pos_ff    <= CODE_PROFILE;
         bc_ff     <= '0;
         lz_ff     <= '0;
         acc_ff    <= '0;
         skip_ff   <= '0;
         prof_ff   <= '0;
         chroma_ff <= 32'd1;
         flags_ff  <= '0;
         done_ff   <= 1'b0;
         for (int i = 0; i < 6; i++) sizes_ff[i] <= '0;
      end else begin
         state_ff  <= state_in;
         ov_ff     <= ov_in;
         bytes_ff  <= bytes_in;
         pos_ff    <= pos_in;
         bc_ff     <= bc_in;
         lz_ff     <= lz_in;
         acc_ff    <= acc_in;
         skip_ff   <= skip_in;
         prof_ff   <= prof_in;
         chroma_ff <= chroma_in;
         flags_ff  <= flags_in;
         done_ff   <= done_in;
         sizes_ff  <= sizes_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in; bitidx_ff <= bitidx_in; last_ff <= last_in; pend_ff <= pend_in;
      w_ff <= w_in; h_ff <= h_in; cw_ff <= cw_in; ch_ff <= ch_in; hres_ff <= hres_in;
      ocode_ff <= ocode_in; oval_ff <= oval_in; ostat_ff <= ostat_in; ofin_ff <= ofin_in;
   end

   a_lz_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, lz_ff} < MaxBits) else $error("leading zero count out of range");
   a_height_after_width: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_FIN_H |-> $past(state_ff) == B_FIN_W || $past(state_ff) == B_FIN_H)
      else $error("height stage entered out of order");
   a_done_clears_at_end: assert property (@(posedge clock) disable iff (reset)
      $fell(done_ff) |-> $past(state_ff) == B_END)
      else $error("parse end cleared outside end of byte");

endmodule

FILE: hdl/h264_sps_header_parser.sv
// H.264 SPS header parser, top level: byte queue front and bit-serial parser back.
// Throughput: one bit per cycle in the back decoder; after the VUI flag bit the size
// computation gives the width and height results, or one error result, and a stalled
// result port holds the decoder.
// Reset (synchronous, active high) empties the queue and restarts at the profile element.
// Depends on sps_pkg, sps_if, sps_front and sps_back.
module h264_sps_header_parser #(
   parameter int MAX_CODE_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   sps_req_if.sink   req_chan,
   sps_rsp_if.source rsp_chan
);
   import sps_pkg::*;

   // The front takes each byte transfer into a two-entry queue, so the
   // input keeps moving while the decoder works through the previous byte.
   logic           q_valid;
   logic           q_pop;
   byte_entry_type q_entry;

   sps_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop)
   );

   // The back shifts each byte out one bit per cycle through the syntax
   // sequencer and holds every result in an output register until its
   // transfer; its bit and result states advance only when that register is free.
   sps_back #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
